/* rtl/core/mma_pkg.sv */
// Shared types and codes for the matrix multiply-accumulate block.
package mma_pkg;

  localparam int unsigned DIM_REG_WIDTH = 5;
  localparam int unsigned CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROWS_M  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COLS_N  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INNER_K = 2'd2;

  localparam logic [DIM_REG_WIDTH-1:0] DIM_RESET = 5'd16;

  localparam logic [2:0] FUNC_LOAD_A = 3'd0;
  localparam logic [2:0] FUNC_LOAD_B = 3'd1;
  localparam logic [2:0] FUNC_LOAD_C = 3'd2;
  localparam logic [2:0] FUNC_RUN    = 3'd3;
  localparam logic [2:0] FUNC_READ_C = 3'd4;

  typedef struct packed {
    logic [2:0]         func;
    logic [7:0]         elem_index;
    logic signed [15:0] operand_value;
    logic signed [47:0] accum_value;
  } in_t;

  typedef struct packed {
    logic [7:0]         out_index;
    logic signed [47:0] out_value;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic rd_en;
    logic mul_en;
    logic acc_en;
    logic done;
  } run_ctrl_t;

endpackage

/* rtl/core/matrix_multiply_accumulate.sv */
// Top level of the matrix multiply-accumulate block with its A, B and C stores.
//
// Usage: an item transfers at a rising edge where start is high and busy is low.
// Loads of A, B or C write one element in the cycle of the transfer and leave busy
// low, so loads may follow back to back. A load with an index outside the
// configured matrix is dropped; a load of C also clears the saturation flag.
// A run item computes C += A*B with one multiplier and one saturating adder;
// each multiply-accumulate step passes through a store read, a multiply, and an
// accumulate and write back, and busy stays high until the last step has written
// back. If any dimension is zero the run does nothing and busy stays low.
// A read of C raises busy while the result passes from the C store read register
// to the result register, strobed by result_valid for exactly one cycle; reads
// with an index at or beyond M*N give no result. The receiver cannot stall results.
// Configuration writes via cfg_we, cfg_index and cfg_data take effect at once
// and must only be made while the block is idle.
// Synchronous reset sets every dimension to 16, clears the saturation flag and
// returns to idle; store contents are undefined until written.
module matrix_multiply_accumulate #(
  parameter int MAX_DIM       = 16,
  parameter int OPERAND_WIDTH = 16,
  parameter int ACCUM_WIDTH   = 48
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  mma_pkg::in_t                            item,
  output logic                                    result_valid,
  output mma_pkg::out_t                           result,
  input  logic                                    cfg_we,
  input  logic [mma_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [mma_pkg::DIM_REG_WIDTH-1:0]       cfg_data
);

  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int AWD   = $clog2(MAX_DIM * MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int CMPW  = (2 * DW > 8) ? 2 * DW : 8;

  typedef enum logic [1:0] {T_IDLE, T_RUN, T_READ} state_t;

  state_t                                  state;
  logic [mma_pkg::DIM_REG_WIDTH-1:0]       rows_m, cols_n, inner_k;
  logic [DW-1:0]                           m_eff, n_eff, k_eff;
  logic [CMPW-1:0]                         idx_ext, size_mk, size_kn, size_mn;
  logic                                    accept, in_a, in_b, in_c, go;
  logic                                    sat_sticky;
  logic [7:0]                              idx_hold;
  logic [AWD-1:0]                          idx_addr;

  logic [OPERAND_WIDTH-1:0]                a_store [DEPTH];
  logic [OPERAND_WIDTH-1:0]                b_store [DEPTH];
  logic [ACCUM_WIDTH-1:0]                  c_store [DEPTH];
  logic [OPERAND_WIDTH-1:0]                a_q, b_q;
  logic [ACCUM_WIDTH-1:0]                  c_q;
  logic                                    c_rd_en, c_we;
  logic [AWD-1:0]                          c_rd_addr, c_wr_addr;
  logic [ACCUM_WIDTH-1:0]                  c_wr_data;

  mma_pkg::run_ctrl_t                      ctrl;
  logic [AWD-1:0]                          a_addr, b_addr, c_addr;
  logic signed [ACCUM_WIDTH-1:0]           mac_sum;
  logic                                    mac_ovf;

  assign busy   = (state != T_IDLE);
  assign accept = start && !busy;

  assign m_eff = (32'(rows_m)  > MAX_DIM) ? DW'(MAX_DIM) : DW'(rows_m);
  assign n_eff = (32'(cols_n)  > MAX_DIM) ? DW'(MAX_DIM) : DW'(cols_n);
  assign k_eff = (32'(inner_k) > MAX_DIM) ? DW'(MAX_DIM) : DW'(inner_k);

  assign size_mk = CMPW'(m_eff) * CMPW'(k_eff);
  assign size_kn = CMPW'(k_eff) * CMPW'(n_eff);
  assign size_mn = CMPW'(m_eff) * CMPW'(n_eff);
  assign idx_ext = CMPW'(item.elem_index);
  assign idx_addr = AWD'(item.elem_index);

  assign in_a = accept && (item.func == mma_pkg::FUNC_LOAD_A) && (idx_ext < size_mk);
  assign in_b = accept && (item.func == mma_pkg::FUNC_LOAD_B) && (idx_ext < size_kn);
  assign in_c = accept && (item.func == mma_pkg::FUNC_LOAD_C) && (idx_ext < size_mn);
  assign go   = accept && (item.func == mma_pkg::FUNC_RUN) &&
                (m_eff != '0) && (n_eff != '0) && (k_eff != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m  <= mma_pkg::DIM_RESET;
      cols_n  <= mma_pkg::DIM_RESET;
      inner_k <= mma_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mma_pkg::CFG_ROWS_M:  rows_m  <= cfg_data;
        mma_pkg::CFG_COLS_N:  cols_n  <= cfg_data;
        mma_pkg::CFG_INNER_K: inner_k <= cfg_data;
        default: ;
      endcase
    end
  end

  mma_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .m      (m_eff),
    .n      (n_eff),
    .k      (k_eff),
    .ctrl   (ctrl),
    .a_addr (a_addr),
    .b_addr (b_addr),
    .c_addr (c_addr)
  );

  mma_mac #(
    .OPERAND_WIDTH (OPERAND_WIDTH),
    .ACCUM_WIDTH   (ACCUM_WIDTH)
  ) u_mac (
    .clk    (clk),
    .mul_en (ctrl.mul_en),
    .a      ($signed(a_q)),
    .b      ($signed(b_q)),
    .c      ($signed(c_q)),
    .sum    (mac_sum),
    .ovf    (mac_ovf)
  );

  always_ff @(posedge clk) begin
    if (in_a) begin
      a_store[idx_addr] <= OPERAND_WIDTH'($signed(item.operand_value));
    end
    if (ctrl.rd_en) begin
      a_q <= a_store[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_b) begin
      b_store[idx_addr] <= OPERAND_WIDTH'($signed(item.operand_value));
    end
    if (ctrl.rd_en) begin
      b_q <= b_store[b_addr];
    end
  end

  assign c_rd_en   = ctrl.rd_en || (accept && (item.func == mma_pkg::FUNC_READ_C));
  assign c_rd_addr = ctrl.rd_en ? c_addr : idx_addr;
  assign c_we      = ctrl.acc_en || in_c;
  assign c_wr_addr = ctrl.acc_en ? c_addr : idx_addr;
  assign c_wr_data = ctrl.acc_en ? mac_sum : ACCUM_WIDTH'($signed(item.accum_value));

  always_ff @(posedge clk) begin
    if (c_we) begin
      c_store[c_wr_addr] <= c_wr_data;
    end
    if (c_rd_en) begin
      c_q <= c_store[c_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_sticky <= 1'b0;
    end else if (in_c) begin
      sat_sticky <= 1'b0;
    end else if (ctrl.acc_en && mac_ovf) begin
      sat_sticky <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (go) begin
            state <= T_RUN;
          end else if (accept && (item.func == mma_pkg::FUNC_READ_C) &&
                       (idx_ext < size_mn)) begin
            idx_hold <= item.elem_index;
            state    <= T_READ;
          end
        end
        T_RUN: begin
          if (ctrl.done) begin
            state <= T_IDLE;
          end
        end
        T_READ: begin
          result_valid     <= 1'b1;
          result.out_index <= idx_hold;
          result.out_value <= 48'($signed(c_q));
          result.saturated <= sat_sticky;
          state            <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/mma_mac.sv */
// Shared multiplier with a saturating accumulator adder.
module mma_mac #(
  parameter int OPERAND_WIDTH = 16,
  parameter int ACCUM_WIDTH   = 48
) (
  input  logic                            clk,
  input  logic                            mul_en,
  input  logic signed [OPERAND_WIDTH-1:0] a,
  input  logic signed [OPERAND_WIDTH-1:0] b,
  input  logic signed [ACCUM_WIDTH-1:0]   c,
  output logic signed [ACCUM_WIDTH-1:0]   sum,
  output logic                            ovf
);

  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int SW = ((ACCUM_WIDTH > PW) ? ACCUM_WIDTH : PW) + 1;
  localparam int HW = SW - ACCUM_WIDTH + 1;

  logic signed [PW-1:0]          prod;
  logic signed [ACCUM_WIDTH-1:0] c_hold;
  logic signed [SW-1:0]          wide_sum;
  logic [HW-1:0]                 top_bits;
  logic signed [ACCUM_WIDTH-1:0] acc_max;
  logic signed [ACCUM_WIDTH-1:0] acc_min;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod   <= a * b;
      c_hold <= c;
    end
  end

  always_comb begin
    acc_max  = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
    acc_min  = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};
    wide_sum = SW'(c_hold) + SW'(prod);
    top_bits = wide_sum[SW-1:ACCUM_WIDTH-1];
    ovf      = (top_bits != '0) && (top_bits != '1);
    if (!ovf) begin
      sum = wide_sum[ACCUM_WIDTH-1:0];
    end else if (wide_sum[SW-1]) begin
      sum = acc_min;
    end else begin
      sum = acc_max;
    end
  end

endmodule

/* rtl/core/mma_seq.sv */
// Loop sequencer that walks p, i and j and issues store addresses for each step.
module mma_seq #(
  parameter int MAX_DIM = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 go,
  input  logic [$clog2(MAX_DIM+1)-1:0]         m,
  input  logic [$clog2(MAX_DIM+1)-1:0]         n,
  input  logic [$clog2(MAX_DIM+1)-1:0]         k,
  output mma_pkg::run_ctrl_t                   ctrl,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   a_addr,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   b_addr,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   c_addr
);

  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int AWD = $clog2(MAX_DIM * MAX_DIM);

  typedef enum logic [1:0] {S_IDLE, S_ADDR, S_MUL, S_ACC} state_t;

  state_t         state;
  logic [DW-1:0]  p, i, j;
  logic [AWD-1:0] a_base, b_base, c_row;
  logic           last_j, last_i, last_p;

  assign last_j = (j == n - DW'(1));
  assign last_i = (i == m - DW'(1));
  assign last_p = (p == k - DW'(1));

  assign a_addr = a_base + AWD'(i);
  assign b_addr = b_base + AWD'(j);
  assign c_addr = c_row + AWD'(j);

  always_comb begin
    ctrl.rd_en  = (state == S_ADDR);
    ctrl.mul_en = (state == S_MUL);
    ctrl.acc_en = (state == S_ACC);
    ctrl.done   = (state == S_ACC) && last_j && last_i && last_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (go) begin
            p      <= '0;
            i      <= '0;
            j      <= '0;
            a_base <= '0;
            b_base <= '0;
            c_row  <= '0;
            state  <= S_ADDR;
          end
        end
        S_ADDR: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          state <= S_ADDR;
          if (!last_j) begin
            j <= j + DW'(1);
          end else begin
            j <= '0;
            if (!last_i) begin
              i     <= i + DW'(1);
              c_row <= c_row + AWD'(n);
            end else begin
              i     <= '0;
              c_row <= '0;
              if (last_p) begin
                state <= S_IDLE;
              end else begin
                p      <= p + DW'(1);
                a_base <= a_base + AWD'(m);
                b_base <= b_base + AWD'(n);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* dv/mma_result_checker.sv */
// Checker that predicts and compares the read-back results of the multiply-accumulate block.
`timescale 1ns / 1ps
module mma_result_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  mma_pkg::in_t                        item,
  input  logic                                result_valid,
  input  mma_pkg::out_t                       result,
  input  logic                                cfg_we,
  input  logic [mma_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [mma_pkg::DIM_REG_WIDTH-1:0]   cfg_data,
  output int                                  mismatch_count,
  output int                                  outstanding,
  output int                                  results_checked,
  output int                                  sat_seen
);

  localparam int unsigned MAX_DIM = 16;
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam longint SUM_MAX = (longint'(1) <<< 47) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  logic [mma_pkg::DIM_REG_WIDTH-1:0] rows_q, cols_q, inner_q;
  logic signed [15:0]                a_mem [DEPTH];
  logic signed [15:0]                b_mem [DEPTH];
  logic signed [47:0]                c_mem [DEPTH];
  logic                              sat_flag;
  mma_pkg::out_t                     pending_reads [$];

  function automatic int unsigned clamp_dim(logic [mma_pkg::DIM_REG_WIDTH-1:0] r);
    return (r > MAX_DIM) ? MAX_DIM : r;
  endfunction

  task automatic multiply_accumulate(int unsigned m, int unsigned n, int unsigned k);
    longint      acc;
    int unsigned ci;
    for (int unsigned p = 0; p < k; p++) begin
      for (int unsigned i = 0; i < m; i++) begin
        for (int unsigned j = 0; j < n; j++) begin
          ci  = i * n + j;
          acc = longint'(c_mem[ci]) +
                longint'(a_mem[i + p * m]) * longint'(b_mem[p * n + j]);
          if (acc > SUM_MAX) begin
            acc      = SUM_MAX;
            sat_flag = 1'b1;
          end else if (acc < SUM_MIN) begin
            acc      = SUM_MIN;
            sat_flag = 1'b1;
          end
          c_mem[ci] = acc[47:0];
        end
      end
    end
  endtask

  task automatic apply_transfer(mma_pkg::in_t it);
    int unsigned   m, n, k;
    mma_pkg::out_t want;
    m = clamp_dim(rows_q);
    n = clamp_dim(cols_q);
    k = clamp_dim(inner_q);
    case (it.func)
      mma_pkg::FUNC_LOAD_A: begin
        if (it.elem_index < m * k) a_mem[it.elem_index] = it.operand_value;
      end
      mma_pkg::FUNC_LOAD_B: begin
        if (it.elem_index < k * n) b_mem[it.elem_index] = it.operand_value;
      end
      mma_pkg::FUNC_LOAD_C: begin
        if (it.elem_index < m * n) begin
          c_mem[it.elem_index] = it.accum_value;
          sat_flag = 1'b0;
        end
      end
      mma_pkg::FUNC_RUN: multiply_accumulate(m, n, k);
      mma_pkg::FUNC_READ_C: begin
        if (it.elem_index < m * n) begin
          want.out_index = it.elem_index;
          want.out_value = c_mem[it.elem_index];
          want.saturated = sat_flag;
          pending_reads.push_back(want);
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_result(mma_pkg::out_t got);
    mma_pkg::out_t want;
    if (pending_reads.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: result with none expected: index %0d value %0d sat %0b",
                 $realtime, got.out_index, got.out_value, got.saturated);
    end else begin
      want = pending_reads.pop_front();
      if (got.out_index !== want.out_index || got.out_value !== want.out_value ||
          got.saturated !== want.saturated) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display({"%0t: mismatch: expected index %0d value %0d sat %0b, ",
                    "got index %0d value %0d sat %0b"},
                   $realtime, want.out_index, want.out_value, want.saturated,
                   got.out_index, got.out_value, got.saturated);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_q          = mma_pkg::DIM_RESET;
      cols_q          = mma_pkg::DIM_RESET;
      inner_q         = mma_pkg::DIM_RESET;
      sat_flag        = 1'b0;
      mismatch_count  = 0;
      results_checked = 0;
      sat_seen        = 0;
      pending_reads.delete();
    end else begin
      if (result_valid) begin
        results_checked++;
        if (result.saturated) sat_seen++;
        compare_result(result);
      end
      if (start && !busy) apply_transfer(item);
      if (cfg_we) begin
        case (cfg_index)
          mma_pkg::CFG_ROWS_M:  rows_q = cfg_data;
          mma_pkg::CFG_COLS_N:  cols_q = cfg_data;
          mma_pkg::CFG_INNER_K: inner_q = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= pending_reads.size();
  end

endmodule

/* dv/tb_matrix_multiply_accumulate.sv */
// Testbench top for the matrix multiply-accumulate block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_matrix_multiply_accumulate;

  localparam int unsigned MAX_DIM = 16;
  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned TARGET_TRANSFERS = 800;
  localparam int unsigned IDLE_PCT = 36;
  localparam int TIMEOUT_NS = 15_000_000;
  localparam logic [mma_pkg::CFG_INDEX_WIDTH-1:0] CFG_SPARE = 2'd3;
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};
  localparam logic signed [15:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [15:0] Q15_MIN = 16'sh8000;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                start;
  logic                                busy;
  mma_pkg::in_t                        item;
  logic                                result_valid;
  mma_pkg::out_t                       result;
  logic                                cfg_we;
  logic [mma_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [mma_pkg::DIM_REG_WIDTH-1:0]   cfg_data;

  int mismatch_count, outstanding, results_checked, sat_seen;

  int unsigned rows_eff, cols_eff, inner_eff;
  int unsigned transfer_count, run_count, phase_count, idle_pct;
  bit          a_written [STORE_DEPTH];
  bit          b_written [STORE_DEPTH];
  bit          c_written [STORE_DEPTH];

  always #5 clk = ~clk;

  matrix_multiply_accumulate dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mma_result_checker u_results (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .outstanding(outstanding),
    .results_checked(results_checked), .sat_seen(sat_seen)
  );

  function automatic int unsigned clamp_dim(logic [mma_pkg::DIM_REG_WIDTH-1:0] r);
    return (r > MAX_DIM) ? MAX_DIM : r;
  endfunction

  function automatic logic signed [15:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return Q15_MIN;
      1: return Q15_MAX;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [47:0] rand_accum();
    case ($urandom_range(0, 7))
      0, 1, 2: return {16'($urandom), 32'($urandom)};
      3: return ACC_MAX - 48'($urandom);
      4: return ACC_MIN + 48'($urandom);
      5: return 48'($signed($urandom));
      6: return '0;
      default: return $urandom_range(0, 1) ? ACC_MAX : ACC_MIN;
    endcase
  endfunction

  function automatic logic [7:0] pick_index(int unsigned lim);
    if (lim >= STORE_DEPTH) return 8'($urandom_range(0, 255));
    if (lim == 0 || $urandom_range(0, 4) == 0) return 8'($urandom_range(lim, 255));
    return 8'($urandom_range(0, lim - 1));
  endfunction

  task automatic send_item(input logic [2:0] func, input logic [7:0] idx,
                           input logic signed [15:0] opv, input logic signed [47:0] accv);
    idle_pct = (transfer_count >= 300 && transfer_count < 480) ? 0 : IDLE_PCT;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= {func, idx, opv, accv};
    @(posedge clk);
    while (busy) @(posedge clk);
    transfer_count++;
    case (func)
      mma_pkg::FUNC_LOAD_A: if (idx < rows_eff * inner_eff) a_written[idx] = 1'b1;
      mma_pkg::FUNC_LOAD_B: if (idx < inner_eff * cols_eff) b_written[idx] = 1'b1;
      mma_pkg::FUNC_LOAD_C: if (idx < rows_eff * cols_eff) c_written[idx] = 1'b1;
      mma_pkg::FUNC_RUN: run_count++;
      default: ;
    endcase
  endtask

  task automatic send_random(input logic [2:0] func, input logic [7:0] idx);
    send_item(func, idx, rand_operand(), rand_accum());
  endtask

  task automatic write_reg(input logic [mma_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [mma_pkg::DIM_REG_WIDTH-1:0] data);
    while ($urandom_range(0, 99) < idle_pct) begin
      cfg_we <= 1'b0;
      @(posedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      mma_pkg::CFG_ROWS_M:  rows_eff = clamp_dim(data);
      mma_pkg::CFG_COLS_N:  cols_eff = clamp_dim(data);
      mma_pkg::CFG_INNER_K: inner_eff = clamp_dim(data);
      default: ;
    endcase
  endtask

  task automatic set_dims(input logic [mma_pkg::DIM_REG_WIDTH-1:0] m,
                          input logic [mma_pkg::DIM_REG_WIDTH-1:0] n,
                          input logic [mma_pkg::DIM_REG_WIDTH-1:0] k, input bit spare);
    write_reg(mma_pkg::CFG_ROWS_M, m);
    write_reg(mma_pkg::CFG_COLS_N, n);
    write_reg(mma_pkg::CFG_INNER_K, k);
    if (spare) write_reg(CFG_SPARE, 5'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("matrix_multiply_accumulate verification failed");
    $finish;
  end

  initial begin
    logic [mma_pkg::DIM_REG_WIDTH-1:0] dm, dn, dk, big;
    int unsigned                       n_ops, sel, cells, n_reads, which;
    bit                                fresh_a, fresh_b, fresh_c;

    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rows_eff  = MAX_DIM;
    cols_eff  = MAX_DIM;
    inner_eff = MAX_DIM;
    idle_pct  = IDLE_PCT;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Operands at both Q1.15 limits drive one C element past each accumulator bound.
    set_dims(5'd2, 5'd2, 5'd2, 1'b1);
    send_item(mma_pkg::FUNC_LOAD_A, 8'd0, Q15_MIN, rand_accum());
    send_item(mma_pkg::FUNC_LOAD_A, 8'd1, Q15_MAX, rand_accum());
    send_item(mma_pkg::FUNC_LOAD_A, 8'd2, Q15_MIN, rand_accum());
    send_item(mma_pkg::FUNC_LOAD_A, 8'd3, 16'sd0, rand_accum());
    send_item(mma_pkg::FUNC_LOAD_B, 8'd0, Q15_MIN, rand_accum());
    send_item(mma_pkg::FUNC_LOAD_B, 8'd1, Q15_MAX, rand_accum());
    send_item(mma_pkg::FUNC_LOAD_B, 8'd2, Q15_MIN, rand_accum());
    send_item(mma_pkg::FUNC_LOAD_B, 8'd3, Q15_MAX, rand_accum());
    send_item(mma_pkg::FUNC_LOAD_C, 8'd0, rand_operand(), ACC_MAX);
    send_item(mma_pkg::FUNC_LOAD_C, 8'd1, rand_operand(), ACC_MIN);
    send_item(mma_pkg::FUNC_LOAD_C, 8'd2, rand_operand(), '0);
    send_item(mma_pkg::FUNC_LOAD_C, 8'd3, rand_operand(), -48'sd1);
    send_item(mma_pkg::FUNC_LOAD_A, 8'd4, Q15_MAX, rand_accum());
    send_item(mma_pkg::FUNC_LOAD_B, 8'd255, Q15_MIN, rand_accum());
    send_item(FUNC_SPARE_LO, 8'd0, rand_operand(), rand_accum());
    send_item(FUNC_SPARE_HI, 8'd255, rand_operand(), rand_accum());
    send_item(mma_pkg::FUNC_RUN, 8'd0, rand_operand(), rand_accum());
    send_item(mma_pkg::FUNC_LOAD_C, 8'd255, rand_operand(), '0);
    for (int unsigned r = 0; r < 4; r++) send_random(mma_pkg::FUNC_READ_C, 8'(r));
    send_random(mma_pkg::FUNC_READ_C, 8'd255);
    send_item(mma_pkg::FUNC_LOAD_C, 8'd2, rand_operand(), '0);
    send_random(mma_pkg::FUNC_READ_C, 8'd2);
    wait_quiet();

    phase_count = 1;
    while (transfer_count < TARGET_TRANSFERS) begin
      case (phase_count)
        1: {dm, dn, dk} = {5'd16, 5'd16, 5'd1};
        2: {dm, dn, dk} = {5'd31, 5'd2, 5'd1};
        3: {dm, dn, dk} = {5'd1, 5'd0, 5'd3};
        4: {dm, dn, dk} = {5'd1, 5'd1, 5'd1};
        5: {dm, dn, dk} = {5'd1, 5'd1, 5'd31};
        6: {dm, dn, dk} = {5'd2, 5'd31, 5'd2};
        7: {dm, dn, dk} = {5'd0, 5'd3, 5'd3};
        8: {dm, dn, dk} = {5'd3, 5'd3, 5'd0};
        default: begin
          dm    = 5'($urandom_range(1, 5));
          dn    = 5'($urandom_range(1, 5));
          dk    = 5'($urandom_range(1, 5));
          which = $urandom_range(0, 2);
          case ($urandom_range(0, 7))
            0: big = 5'($urandom_range(16, 31));
            1: big = 5'd0;
            default: big = (which == 0) ? dm : (which == 1) ? dn : dk;
          endcase
          case (which)
            0: dm = big;
            1: dn = big;
            default: dk = big;
          endcase
        end
      endcase
      set_dims(dm, dn, dk, $urandom_range(0, 3) == 0);

      fresh_a = $urandom_range(0, 1);
      fresh_b = $urandom_range(0, 1);
      fresh_c = $urandom_range(0, 1);
      for (int unsigned x = 0; x < rows_eff * inner_eff; x++)
        if (fresh_a || !a_written[x]) send_random(mma_pkg::FUNC_LOAD_A, 8'(x));
      for (int unsigned x = 0; x < inner_eff * cols_eff; x++)
        if (fresh_b || !b_written[x]) send_random(mma_pkg::FUNC_LOAD_B, 8'(x));
      for (int unsigned x = 0; x < rows_eff * cols_eff; x++)
        if (fresh_c || !c_written[x]) send_random(mma_pkg::FUNC_LOAD_C, 8'(x));
      send_random(mma_pkg::FUNC_RUN, 8'($urandom));

      cells   = rows_eff * cols_eff;
      n_reads = (cells <= 32) ? cells : 24;
      for (int unsigned r = 0; r < n_reads; r++)
        send_random(mma_pkg::FUNC_READ_C,
                    (cells <= 32) ? 8'(r) : 8'($urandom_range(0, cells - 1)));

      n_ops = $urandom_range(8, 40);
      repeat (n_ops) begin
        sel = $urandom_range(0, 99);
        if (sel < 15) send_random(mma_pkg::FUNC_LOAD_A, pick_index(rows_eff * inner_eff));
        else if (sel < 30) send_random(mma_pkg::FUNC_LOAD_B, pick_index(inner_eff * cols_eff));
        else if (sel < 42) send_random(mma_pkg::FUNC_LOAD_C, pick_index(cells));
        else if (sel < 50) send_random(mma_pkg::FUNC_RUN, 8'($urandom));
        else if (sel < 88) send_random(mma_pkg::FUNC_READ_C, pick_index(cells));
        else if (sel < 94)
          send_random(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), 8'($urandom));
        else wait_quiet();
      end
      wait_quiet();
      phase_count++;
    end

    $display("Covered %0d transfers over %0d dimension settings, including %0d multiply runs.",
             transfer_count, phase_count, run_count);
    $display("Checked %0d read-back results, %0d of them with the saturation flag set.",
             results_checked, sat_seen);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("matrix_multiply_accumulate verification clean");
    end else begin
      $display("matrix_multiply_accumulate verification failed");
    end
    $finish;
  end

endmodule

/* matrix_multiply_accumulate.f */
rtl/core/mma_pkg.sv
rtl/core/mma_mac.sv
rtl/core/mma_seq.sv
rtl/core/matrix_multiply_accumulate.sv
dv/mma_result_checker.sv
dv/tb_matrix_multiply_accumulate.sv
